// ===== rtl/core/char_lcd_write_sequencer_defines.svh =====
// Assertion macros used by the back end of the character LCD write sequencer.
`ifndef CHAR_LCD_WRITE_SEQUENCER_DEFINES_SVH
`define CHAR_LCD_WRITE_SEQUENCER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CLWS_ASSERT_IMP(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define CLWS_ASSERT_NXT(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/clws_pkg.sv =====
// Types, constants and helpers for the character LCD write sequencer.
package clws_pkg;

  localparam int HOLD_COUNT_WIDTH = 20;
  localparam logic [HOLD_COUNT_WIDTH-1:0] HOLD_RESET = HOLD_COUNT_WIDTH'(50000);

  localparam logic [7:0] LOW_NIBBLE_MASK  = 8'h0F;
  localparam logic [7:0] HIGH_NIBBLE_MASK = 8'hF0;
  localparam logic [7:0] ROW1_OFFSET      = 8'h40;
  localparam logic [7:0] CURSOR_CMD       = 8'h80;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_CMD    = 2'd0,
    OP_CHAR   = 2'd1,
    OP_CURSOR = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_BUS_MODE    = 2'd0,
    REG_NIBBLE_LANE = 2'd1,
    REG_HOLD_CYCLES = 2'd2,
    REG_UNUSED      = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    PH_RS      = 3'd0,
    PH_E_HI1   = 3'd1,
    PH_DATA_HI = 3'd2,
    PH_E_LO1   = 3'd3,
    PH_E_HI2   = 3'd4,
    PH_DATA_LO = 3'd5,
    PH_E_LO2   = 3'd6
  } phase_t;

  // One classified write: RS level and the byte to put on the bus.
  typedef struct packed {
    logic       rs;
    logic [7:0] code;
  } lcd_req_t;

  typedef struct packed {
    logic                        bus_mode;
    logic                        nibble_lane;
    logic [HOLD_COUNT_WIDTH-1:0] hold_cycles;
  } cfg_t;

  // Queue status seen by the producer and the consumer.
  typedef struct packed {
    logic full;
    logic not_empty;
  } q_status_t;

  // Places a nibble on the chosen lane and keeps the other four pins.
  function automatic logic [7:0] drive_nibble(input logic [7:0] bus,
                                              input logic [3:0] nib,
                                              input logic       lane);
    logic [7:0] result;
    if (lane) begin
      result = (bus & LOW_NIBBLE_MASK) | {nib, 4'h0};
    end else begin
      result = (bus & HIGH_NIBBLE_MASK) | {4'h0, nib};
    end
    return result;
  endfunction

endpackage

// ===== rtl/core/clws_front.sv =====
// Front end: takes requests, drops undefined ones, forms the command byte.
module clws_front import clws_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  logic [1:0] operation,
  input  logic [7:0] byte_value,
  input  logic [1:0] row,
  input  logic [5:0] column,
  input  q_status_t q_status,
  output logic      push,
  output lcd_req_t  push_req
);

  logic     item_valid;
  lcd_req_t item;
  lcd_req_t classified;
  logic     accept;
  logic [7:0] cursor_addr;

  always_comb begin
    case (row)
      2'd0:    cursor_addr = {2'b00, column};
      2'd1:    cursor_addr = ROW1_OFFSET | {2'b00, column};
      default: cursor_addr = 8'h00;
    endcase
  end

  always_comb begin
    classified.rs   = (op_t'(operation) == OP_CHAR);
    classified.code = (op_t'(operation) == OP_CURSOR) ? (CURSOR_CMD | cursor_addr)
                                                      : byte_value;
  end

  assign in_stall = item_valid && q_status.full;
  assign accept   = in_valid && !in_stall;
  assign push     = item_valid && !q_status.full;
  assign push_req = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= (op_t'(operation) != OP_NONE);
    end else if (push) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= classified;
    end
  end

endmodule

// ===== rtl/core/clws_queue.sv =====
// Short request queue between the front end and the pin sequencer.
module clws_queue import clws_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  lcd_req_t  push_req,
  input  logic      pop,
  output lcd_req_t  head,
  output q_status_t q_status
);

  lcd_req_t             entries [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr;
  logic [Q_PTR_W-1:0]   rd_ptr;
  logic [Q_CNT_W-1:0]   count;
  logic [Q_CNT_W-1:0]   count_next;

  assign q_status.full      = (count == Q_CNT_W'(Q_DEPTH));
  assign q_status.not_empty = (count != '0);
  assign head               = entries[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + Q_CNT_W'(1);
    end else if (pop && !push) begin
      count_next = count - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + Q_PTR_W'(1);
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_req;
    end
  end

endmodule

// ===== rtl/core/clws_back.sv =====
// Back end: steps through the pin states of one write and paces them.
module clws_back import clws_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  lcd_req_t   head,
  input  logic       head_valid,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       reg_select,
  output logic       read_write,
  output logic       enable,
  output logic [7:0] data_bus,
  output logic       last
);

`include "char_lcd_write_sequencer_defines.svh"

  phase_t phase;
  phase_t phase_next;

  logic       select_level;
  logic       strobe_level;
  logic [7:0] bus_levels;
  logic       last_flag;

  logic       select_level_next;
  logic       strobe_level_next;
  logic [7:0] bus_levels_next;
  logic       final_phase;

  logic [HOLD_COUNT_WIDTH-1:0] gap_cnt;
  logic                        load;
  logic                        out_take;

  assign out_take = out_valid && !out_stall;
  // A new pin state goes out once the previous one has been taken and held.
  assign load     = (!out_valid || out_take) && (gap_cnt == '0) && head_valid;
  assign pop      = load && final_phase;

  always_comb begin
    phase_next = phase;
    if (load) begin
      case (phase)
        PH_RS:      phase_next = PH_E_HI1;
        PH_E_HI1:   phase_next = PH_DATA_HI;
        PH_DATA_HI: phase_next = PH_E_LO1;
        PH_E_LO1:   phase_next = cfg.bus_mode ? PH_E_HI2 : PH_RS;
        PH_E_HI2:   phase_next = PH_DATA_LO;
        PH_DATA_LO: phase_next = PH_E_LO2;
        PH_E_LO2:   phase_next = PH_RS;
        default:    phase_next = PH_RS;
      endcase
    end
  end

  always_comb begin
    select_level_next = select_level;
    strobe_level_next = strobe_level;
    bus_levels_next   = bus_levels;
    final_phase       = 1'b0;
    case (phase)
      PH_RS:      select_level_next = head.rs;
      PH_E_HI1:   strobe_level_next = 1'b1;
      PH_DATA_HI: begin
        if (cfg.bus_mode) begin
          bus_levels_next = drive_nibble(bus_levels, head.code[7:4], cfg.nibble_lane);
        end else begin
          bus_levels_next = head.code;
        end
      end
      PH_E_LO1: begin
        strobe_level_next = 1'b0;
        final_phase       = !cfg.bus_mode;
      end
      PH_E_HI2:   strobe_level_next = 1'b1;
      PH_DATA_LO: bus_levels_next = drive_nibble(bus_levels, head.code[3:0],
                                                 cfg.nibble_lane);
      PH_E_LO2: begin
        strobe_level_next = 1'b0;
        final_phase       = 1'b1;
      end
      default:    final_phase = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_RS;
      out_valid    <= 1'b0;
      gap_cnt      <= '0;
      select_level <= 1'b0;
      strobe_level <= 1'b0;
      bus_levels   <= '0;
      last_flag    <= 1'b0;
    end else begin
      phase <= phase_next;
      if (load) begin
        out_valid    <= 1'b1;
        select_level <= select_level_next;
        strobe_level <= strobe_level_next;
        bus_levels   <= bus_levels_next;
        last_flag    <= final_phase;
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
      // The hold period starts when a pin state is driven; zero counts as one.
      if (load) begin
        gap_cnt <= (cfg.hold_cycles == '0) ? '0
                                           : cfg.hold_cycles - HOLD_COUNT_WIDTH'(1);
      end else if (gap_cnt != '0) begin
        gap_cnt <= gap_cnt - HOLD_COUNT_WIDTH'(1);
      end
    end
  end

  assign reg_select = select_level;
  assign read_write = 1'b0;
  assign enable     = strobe_level;
  assign data_bus   = bus_levels;
  assign last       = last_flag;

  `CLWS_ASSERT_IMP(a_last_strobe_low, clk, rst, out_valid && last_flag, !strobe_level, "last pin state has E high")
  `CLWS_ASSERT_NXT(a_pop_shows_last, clk, rst, pop, out_valid && last_flag, "request retired without a last pin state")
  `CLWS_ASSERT_IMP(a_hold_respected, clk, rst, gap_cnt != '0, !load, "pin state issued during hold period")

endmodule

// ===== rtl/core/char_lcd_write_sequencer.sv =====
// Character LCD write sequencer: each request (command byte, character byte or
// cursor move) becomes the run of RS/RW/E/data pin states of one parallel
// write, 4 states on an eight-bit bus and 7 in four-bit mode. Each pin state
// stays on the pins for at least the hold period in hold_cycles (a value of
// 0 acts as 1), longer while the output channel is stalled; the hold counter
// in the pin sequencer paces it. A four-entry request queue lets new requests
// be accepted while a write is under way. Configuration is written through
// the APB port at byte addresses 0 (bus_mode), 4 (nibble_lane) and 8
// (hold_cycles).
module char_lcd_write_sequencer import clws_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [7:0]  byte_value,
  input  logic [1:0]  row,
  input  logic [5:0]  column,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        reg_select,
  output logic        read_write,
  output logic        enable,
  output logic [7:0]  data_bus,
  output logic        last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t      cfg;
  q_status_t q_status;
  logic      push;
  lcd_req_t  push_req;
  logic      pop;
  lcd_req_t  head;
  logic      cfg_write;
  reg_idx_t  reg_idx;

  assign pready    = 1'b1;
  assign reg_idx   = reg_idx_t'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bus_mode    <= 1'b0;
      cfg.nibble_lane <= 1'b1;
      cfg.hold_cycles <= HOLD_RESET;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_BUS_MODE:    cfg.bus_mode    <= pwdata[0];
        REG_NIBBLE_LANE: cfg.nibble_lane <= pwdata[0];
        REG_HOLD_CYCLES: cfg.hold_cycles <= pwdata[HOLD_COUNT_WIDTH-1:0];
        default:         cfg.bus_mode    <= cfg.bus_mode;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_BUS_MODE:    prdata = {31'b0, cfg.bus_mode};
      REG_NIBBLE_LANE: prdata = {31'b0, cfg.nibble_lane};
      REG_HOLD_CYCLES: prdata = {{(32-HOLD_COUNT_WIDTH){1'b0}}, cfg.hold_cycles};
      default:         prdata = '0;
    endcase
  end

  clws_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .operation  (operation),
    .byte_value (byte_value),
    .row        (row),
    .column     (column),
    .q_status   (q_status),
    .push       (push),
    .push_req   (push_req)
  );

  clws_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_req (push_req),
    .pop      (pop),
    .head     (head),
    .q_status (q_status)
  );

  clws_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head       (head),
    .head_valid (q_status.not_empty),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .reg_select (reg_select),
    .read_write (read_write),
    .enable     (enable),
    .data_bus   (data_bus),
    .last       (last)
  );

endmodule

// ===== bench/char_lcd_write_sequencer_tb.sv =====
// Self-checking testbench for the character LCD write sequencer.
module char_lcd_write_sequencer_tb;
  import clws_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    op_t        op;
    logic [7:0] byte_v;
    logic [1:0] row;
    logic [5:0] column;
  } lcd_request_t;

  typedef struct {
    logic       rs;
    logic       rw;
    logic       e;
    logic [7:0] bus;
    logic       fin;
  } pin_state_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  operation = '0;
  logic [7:0]  byte_value = '0;
  logic [1:0]  row = '0;
  logic [5:0]  column = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        reg_select;
  logic        read_write;
  logic        enable;
  logic [7:0]  data_bus;
  logic        last;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  char_lcd_write_sequencer u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .operation  (operation),
    .byte_value (byte_value),
    .row        (row),
    .column     (column),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .reg_select (reg_select),
    .read_write (read_write),
    .enable     (enable),
    .data_bus   (data_bus),
    .last       (last),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // Pin levels and register settings as the LCD interface should see them.
  logic [7:0] lcd_bus_levels = 8'h00;
  logic       lcd_rs = 1'b0;
  logic       lcd_e = 1'b0;
  logic       nibble_mode = 1'b0;
  logic       lane_high = 1'b1;
  int         hold_now = 50000;

  lcd_request_t pending_requests[$];
  pin_state_t   pins_expected[$];
  lcd_request_t presented;
  pin_state_t   observed_want;

  int idle_pct = 30;
  int fails = 0;
  int requests_accepted = 0;
  int pins_checked = 0;
  int settings_used = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic void push_pin(logic fin);
    pins_expected.push_back('{lcd_rs, 1'b0, lcd_e, lcd_bus_levels, fin});
  endfunction

  function automatic void put_nibble(logic [3:0] nib);
    if (lane_high) begin
      lcd_bus_levels = {nib, lcd_bus_levels[3:0]};
    end else begin
      lcd_bus_levels = {lcd_bus_levels[7:4], nib};
    end
  endfunction

  // Expands one accepted request into the pin states of its write cycle.
  function automatic void predict_lcd_write(lcd_request_t req);
    logic [7:0] code;
    logic [7:0] addr;
    if (req.op == OP_NONE) return;
    code = req.byte_v;
    if (req.op == OP_CURSOR) begin
      case (req.row)
        2'd0: addr = {2'b00, req.column};
        2'd1: addr = ROW1_OFFSET + {2'b00, req.column};
        default: addr = 8'h00;
      endcase
      code = CURSOR_CMD | addr;
    end
    lcd_rs = (req.op == OP_CHAR);
    push_pin(1'b0);
    lcd_e = 1'b1;
    push_pin(1'b0);
    if (nibble_mode) begin
      put_nibble(code[7:4]);
      push_pin(1'b0);
      lcd_e = 1'b0;
      push_pin(1'b0);
      lcd_e = 1'b1;
      push_pin(1'b0);
      put_nibble(code[3:0]);
      push_pin(1'b0);
    end else begin
      lcd_bus_levels = code;
      push_pin(1'b0);
    end
    lcd_e = 1'b0;
    push_pin(1'b1);
  endfunction

  function automatic void compare_pin(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fails++;
    end
  endfunction

  function automatic lcd_request_t mk(op_t op, logic [7:0] b, logic [1:0] r, logic [5:0] c);
    lcd_request_t req;
    req.op = op;
    req.byte_v = b;
    req.row = r;
    req.column = c;
    return req;
  endfunction

  function automatic lcd_request_t random_request();
    lcd_request_t req;
    req.op = ($urandom_range(99) < 8) ? OP_NONE : op_t'($urandom_range(2));
    req.byte_v = 8'($urandom_range(255));
    req.row = 2'($urandom_range(3));
    req.column = ($urandom_range(3) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(39));
    return req;
  endfunction

  // Request driver: the prediction is made at the edge where the transaction
  // is accepted, so it always uses the settings in force at that time.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_lcd_write(presented);
        requests_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_requests.size() > 0 && $urandom_range(99) >= idle_pct) begin
          presented = pending_requests.pop_front();
          in_valid <= 1'b1;
          operation <= presented.op;
          byte_value <= presented.byte_v;
          row <= presented.row;
          column <= presented.column;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Pin state monitor with random back-pressure.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pins_expected.size() == 0) begin
          $error("unexpected pin state: rs=%0b e=%0b bus=0x%0h last=%0b",
                 reg_select, enable, data_bus, last);
          fails++;
        end else begin
          observed_want = pins_expected.pop_front();
          pins_checked++;
          compare_pin("reg_select", 8'(observed_want.rs), 8'(reg_select));
          compare_pin("read_write", 8'(observed_want.rw), 8'(read_write));
          compare_pin("enable", 8'(observed_want.e), 8'(enable));
          compare_pin("data_bus", observed_want.bus, data_bus);
          compare_pin("last", 8'(observed_want.fin), 8'(last));
        end
      end
      out_stall <= ($urandom_range(99) < idle_pct);
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_BUS_MODE:    nibble_mode = value[0];
      REG_NIBBLE_LANE: lane_high = value[0];
      REG_HOLD_CYCLES: hold_now = int'(value[HOLD_COUNT_WIDTH-1:0]);
      default: ;
    endcase
    if (idx == REG_UNUSED) return;
    // Read the register back to confirm the write landed.
    @(posedge clk);
    psel <= 1'b1;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== value) begin
      $error("register %s: expected 0x%0h, got 0x%0h", idx.name(), value, prdata);
      fails++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    settings_used++;
  endtask

  // Waits until every queued request is taken and every pin state has come
  // back, then lets a dropped request or a trailing hold period finish.
  task automatic drain_and_settle();
    do @(negedge clk);
    while (pending_requests.size() != 0 || in_valid || pins_expected.size() != 0);
    repeat (64 + 8 * hold_now) @(posedge clk);
  endtask

  initial begin
    int ph;
    int n;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Eight-bit bus, lane left at its reset value.
    write_reg(REG_HOLD_CYCLES, 32'd1);
    pending_requests.push_back(mk(OP_CMD, 8'h00, 2'd0, 6'd0));
    pending_requests.push_back(mk(OP_CMD, 8'hFF, 2'd3, 6'd63));
    pending_requests.push_back(mk(OP_CHAR, 8'hA5, 2'd1, 6'd21));
    pending_requests.push_back(mk(OP_CHAR, 8'h5A, 2'd2, 6'd42));
    pending_requests.push_back(mk(OP_CURSOR, 8'hFF, 2'd0, 6'd0));
    pending_requests.push_back(mk(OP_CURSOR, 8'h00, 2'd1, 6'd39));
    pending_requests.push_back(mk(OP_CURSOR, 8'h12, 2'd2, 6'd17));
    pending_requests.push_back(mk(OP_CURSOR, 8'h34, 2'd3, 6'd63));
    pending_requests.push_back(mk(OP_CURSOR, 8'h56, 2'd1, 6'd63));
    pending_requests.push_back(mk(OP_NONE, 8'hFF, 2'd3, 6'd63));
    drain_and_settle();

    // Four-bit transfers on the upper pins; a zero hold behaves as one.
    write_reg(REG_BUS_MODE, 32'd1);
    write_reg(REG_HOLD_CYCLES, 32'd0);
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    pending_requests.push_back(mk(OP_CHAR, 8'h3C, 2'd0, 6'd0));
    pending_requests.push_back(mk(OP_CMD, 8'hFF, 2'd0, 6'd0));
    pending_requests.push_back(mk(OP_CURSOR, 8'h00, 2'd1, 6'd63));
    pending_requests.push_back(mk(OP_NONE, 8'h00, 2'd0, 6'd0));
    pending_requests.push_back(mk(OP_CHAR, 8'h00, 2'd2, 6'd5));
    pending_requests.push_back(mk(OP_CURSOR, 8'hC3, 2'd0, 6'd39));
    drain_and_settle();

    // Four-bit transfers on the lower pins; the upper pins must hold.
    write_reg(REG_NIBBLE_LANE, 32'd0);
    write_reg(REG_HOLD_CYCLES, 32'd2);
    pending_requests.push_back(mk(OP_CMD, 8'h0F, 2'd3, 6'd1));
    pending_requests.push_back(mk(OP_CHAR, 8'hF0, 2'd0, 6'd2));
    pending_requests.push_back(mk(OP_CURSOR, 8'h77, 2'd1, 6'd0));
    pending_requests.push_back(mk(OP_CURSOR, 8'h88, 2'd3, 6'd5));
    pending_requests.push_back(mk(OP_NONE, 8'h81, 2'd1, 6'd9));
    pending_requests.push_back(mk(OP_CHAR, 8'h81, 2'd1, 6'd9));
    drain_and_settle();

    // The longest hold is only stored and read back; no request is run at that pace.
    write_reg(REG_HOLD_CYCLES, 32'h000F_FFFF);
    write_reg(REG_HOLD_CYCLES, 32'd3);

    for (ph = 0; ph < 4; ph++) begin
      write_reg(REG_BUS_MODE, (ph == 1 || ph == 2) ? 32'd1 : 32'd0);
      write_reg(REG_NIBBLE_LANE, (ph == 1 || ph == 3) ? 32'd0 : 32'd1);
      write_reg(REG_HOLD_CYCLES, $urandom_range(4, 1));
      idle_pct = (ph == 2) ? 0 : 30;
      for (n = 0; n < 25; n++) begin
        pending_requests.push_back(random_request());
      end
      drain_and_settle();
    end
    idle_pct = 30;

    if (pins_expected.size() != 0) begin
      $error("%0d pin states never arrived", pins_expected.size());
      fails++;
    end
    $display("Covered %0d requests in 8-bit and both 4-bit lanes over %0d register writes,",
             requests_accepted, settings_used);
    $display("with %0d pin states checked field by field.", pins_checked);
    if (fails == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
